### rtl/swds_pkg.sv
// Shared constants for the sliding window density selector.
// Holds register widths, reset values, register indexes and default sizes.
// No dependencies.
package swds_pkg;

    localparam int WINDOW_LENGTH_W  = 21;
    localparam int MAX_UNRETAINED_W = 8;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 21;

    localparam logic [WINDOW_LENGTH_W-1:0]  WINDOW_LENGTH_RESET  = 21'd1000;
    localparam logic [MAX_UNRETAINED_W-1:0] MAX_UNRETAINED_RESET = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_UNRETAINED = 1'b1;

    localparam int QUEUE_DEPTH_DEFAULT    = 256;
    localparam int POSITION_WIDTH_DEFAULT = 31;

endpackage

### rtl/swds_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swds_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sliding_window_density_selector_core.sv
// Top level of the sliding window density selector.
// Depends on swds_pkg (constants) and swds_ram (pending position queue).
//
// Usage:
//   Positions enter one request at a time on the input channel
//   (in_valid/in_ready/position) and must be strictly increasing. For each
//   request exactly one decision leaves on the output channel
//   (out_valid/out_ready/position_out/retain): retain = 1 keeps the
//   position, retain = 0 drops it and queues it as pending.
//   The idle state takes the request; each queue entry examined passes a
//   read state (read the oldest pending position) and a check state
//   (compare against the window start); a decide state makes the decision.
//   The entries examined are the popped ones plus, if any remain, one kept.
//   Averaged over a stream, each item pops at most one entry.
//   The result lands in an output register; the next request is taken while
//   it waits. If the receiver stalls, the decision step holds until the
//   output register is free.
//   Reset clears the queue (head, tail, occupancy) and loads the register
//   defaults: window_length 1000, max_unretained 10. Configuration is
//   written through cfg_write/cfg_index/cfg_data while idle.
module sliding_window_density_selector_core #(
    parameter int QUEUE_DEPTH    = swds_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int POSITION_WIDTH = swds_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [swds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swds_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [POSITION_WIDTH-1:0]        position,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [POSITION_WIDTH-1:0]        position_out,
    output logic                             retain
);

    localparam int PW     = POSITION_WIDTH;
    localparam int WL_W   = swds_pkg::WINDOW_LENGTH_W;
    localparam int MU_W   = swds_pkg::MAX_UNRETAINED_W;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW     = ((PW > WL_W) ? PW : WL_W) + 1;
    localparam int CMP_W  = (OCC_W > MU_W) ? OCC_W : MU_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DECIDE
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW:0]       start_reg, start_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [WL_W-1:0]   window_length_reg, window_length_next;
    logic [MU_W-1:0]   max_unretained_reg, max_unretained_next;
    logic              out_valid_reg, out_valid_next;
    logic [PW-1:0]     out_pos_reg, out_pos_next;
    logic              out_retain_reg, out_retain_next;

    logic              ram_we;
    logic [PW-1:0]     ram_rdata;
    logic [CW-1:0]     pos_ext;
    logic [CW-1:0]     wl_ext;
    logic [CW-1:0]     start_full;
    logic              keep;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    // Pending (dropped) positions, oldest at head_reg.
    swds_ram #(
        .WIDTH (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (pos_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Window start: max(1, p - window_length + 1). A zero-length window at the
    // top position gives a start one above the position range, so keep the
    // extra bit.
    assign pos_ext    = CW'(position);
    assign wl_ext     = CW'(window_length_reg);
    assign start_full = pos_ext - wl_ext + CW'(1);

    // Retain once the window already holds the limit, or the queue is full.
    assign keep = (CMP_W'(occ_reg) >= CMP_W'(max_unretained_reg)) ||
                  (occ_reg == OCC_W'(QUEUE_DEPTH));

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign position_out = out_pos_reg;
    assign retain       = out_retain_reg;

    always_comb
    begin
        state_next          = state_reg;
        pos_next            = pos_reg;
        start_next          = start_reg;
        head_next           = head_reg;
        tail_next           = tail_reg;
        occ_next            = occ_reg;
        window_length_next  = window_length_reg;
        max_unretained_next = max_unretained_reg;
        out_valid_next      = out_valid_reg;
        out_pos_next        = out_pos_reg;
        out_retain_next     = out_retain_reg;
        ram_we              = 1'b0;

        // Drop the result once the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                swds_pkg::REG_WINDOW_LENGTH:  window_length_next  = cfg_data[WL_W-1:0];
                swds_pkg::REG_MAX_UNRETAINED: max_unretained_next = cfg_data[MU_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next = position;
                    if (pos_ext > wl_ext)
                    begin
                        start_next = start_full[PW:0];
                    end
                    else
                    begin
                        start_next = (PW+1)'(1);
                    end
                    state_next = (occ_reg == '0) ? ST_DECIDE : ST_READ;
                end
            end
            ST_READ:
            begin
                // Queue read of the head entry is in flight.
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Pop the head if it lies below the window start.
                if ({1'b0, ram_rdata} < start_reg)
                begin
                    head_next  = next_slot(head_reg);
                    occ_next   = occ_reg - 1'b1;
                    state_next = (occ_reg == OCC_W'(1)) ? ST_DECIDE : ST_READ;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    if (!keep)
                    begin
                        ram_we    = 1'b1;
                        tail_next = next_slot(tail_reg);
                        occ_next  = occ_reg + 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_pos_next    = pos_reg;
                    out_retain_next = keep;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            pos_reg            <= '0;
            start_reg          <= '0;
            head_reg           <= '0;
            tail_reg           <= '0;
            occ_reg            <= '0;
            window_length_reg  <= swds_pkg::WINDOW_LENGTH_RESET;
            max_unretained_reg <= swds_pkg::MAX_UNRETAINED_RESET;
            out_valid_reg      <= 1'b0;
            out_pos_reg        <= '0;
            out_retain_reg     <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            pos_reg            <= pos_next;
            start_reg          <= start_next;
            head_reg           <= head_next;
            tail_reg           <= tail_next;
            occ_reg            <= occ_next;
            window_length_reg  <= window_length_next;
            max_unretained_reg <= max_unretained_next;
            out_valid_reg      <= out_valid_next;
            out_pos_reg        <= out_pos_next;
            out_retain_reg     <= out_retain_next;
        end
    end

endmodule

### tb/tb_top.sv
// Self-checking testbench for sliding_window_density_selector_core.
// Holds the clock, reset, request driver, decision predictor and result checker.
// Depends on swds_pkg and the core RTL only.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = swds_pkg::POSITION_WIDTH_DEFAULT;
    localparam int QD = swds_pkg::QUEUE_DEPTH_DEFAULT;
    localparam longint unsigned POS_MAX = (64'd1 << PW) - 1;
    localparam int unsigned WINDOW_MAX = 1048576;
    localparam int SHOWN_MISMATCHES = 10;

    // One decision as the block reports it.
    typedef struct {
        logic [PW-1:0] pos;
        logic          keep;
    } decision_t;

    // DUT connections; every input starts at a known value.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [swds_pkg::CFG_INDEX_W-1:0] cfg_index = swds_pkg::REG_WINDOW_LENGTH;
    logic [swds_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PW-1:0]         position = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PW-1:0]         position_out;
    logic                  retain;

    // Predictor state: the register copies and the queue of dropped positions.
    logic [swds_pkg::WINDOW_LENGTH_W-1:0]  win_len = swds_pkg::WINDOW_LENGTH_RESET;
    logic [swds_pkg::MAX_UNRETAINED_W-1:0] max_drop = swds_pkg::MAX_UNRETAINED_RESET;
    logic [PW-1:0]               dropped_positions[$];

    // Decisions still owed by the block, oldest first.
    decision_t pending_decisions[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    sliding_window_density_selector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position_out (position_out),
        .retain       (retain)
    );

    always #4 clk = ~clk;

    // Stall the receiver at random; recv_idle_pct of zero gives a clean stretch.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Work out the decision for one accepted request and queue it.
    // Pop the oldest dropped positions that fell out of the window, then
    // keep the new one if the window already holds enough drops or the queue is full.
    function automatic void predict_decision(input logic [PW-1:0] pos);
        longint unsigned p;
        longint unsigned start;
        longint unsigned oldest;
        decision_t d;
        p = pos;
        start = (p > win_len) ? p - win_len + 1 : 1;
        while (dropped_positions.size() > 0)
        begin
            oldest = dropped_positions[0];
            if (oldest + 1 > start)
                break;
            void'(dropped_positions.pop_front());
        end
        d.pos = pos;
        d.keep = (dropped_positions.size() >= int'(max_drop)) ||
                 (dropped_positions.size() >= QD);
        if (!d.keep)
            dropped_positions = {dropped_positions, pos};
        pending_decisions = {pending_decisions, d};
    endfunction

    // Compare every accepted result against the oldest expected decision.
    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decisions.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOWN_MISMATCHES)
                    $display("[%0t] unexpected result: position_out=%0d retain=%0b",
                             $realtime, position_out, retain);
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (position_out !== want.pos || retain !== want.keep)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_MISMATCHES)
                        $display("[%0t] mismatch: expected position %0d retain %0b, got %0d %0b",
                                 $realtime, want.pos, want.keep, position_out, retain);
                end
            end
        end
    end

    // Send one request. Idle first at random, then hold valid and payload
    // until the handshake; valid stays high on return so back-to-back
    // requests never drop it within one step.
    task automatic send_position(input logic [PW-1:0] pos);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_decision(pos);
    endtask

    // Hold off the sender until every owed decision has come back.
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_decisions.size() != 0);
    endtask

    // Write both registers on consecutive edges; call only when idle.
    task automatic set_config(input int unsigned wl, input int unsigned mu);
        cfg_write <= 1'b1;
        cfg_index <= swds_pkg::REG_WINDOW_LENGTH;
        cfg_data  <= swds_pkg::CFG_DATA_W'(wl);
        @(posedge clk);
        win_len   = swds_pkg::WINDOW_LENGTH_W'(wl);
        cfg_index <= swds_pkg::REG_MAX_UNRETAINED;
        cfg_data  <= swds_pkg::CFG_DATA_W'(mu);
        @(posedge clk);
        max_drop  = swds_pkg::MAX_UNRETAINED_W'(mu);
        cfg_write <= 1'b0;
    endtask

    // Reset values: small positions saturate the window start, the largest
    // position flushes the whole queue.
    task automatic test_reset_defaults;
        send_position(PW'(1));
        send_position(PW'(999));
        send_position(PW'(1000));
        send_position(PW'(1001));
        send_position(PW'(POS_MAX));
    endtask

    // Shortest window, zero-length window, then a WINDOW_MAX window with the largest limit.
    task automatic test_window_extremes;
        drain();
        set_config(1, 1);
        send_position(PW'(5));
        send_position(PW'(6));
        send_position(PW'(6));
        drain();
        set_config(0, 2);
        send_position(PW'(10));
        send_position(PW'(10));
        send_position(PW'(9));
        send_position(PW'(POS_MAX));
        drain();
        set_config(WINDOW_MAX, 255);
        send_position(PW'(1048576));
        send_position(PW'(1048577));
        send_position(PW'(2097152));
    endtask

    // Limit of zero: retain everything.
    task automatic test_limit_zero;
        drain();
        set_config(1000, 0);
        send_position(PW'(3000000));
        send_position(PW'(3000001));
    endtask

    // Fill to the limit, then lower it while entries are still queued.
    task automatic test_limit_lowered;
        drain();
        set_config(1000, 5);
        for (int i = 0; i < 5; i++)
            send_position(PW'(4000100 + i));
        drain();
        set_config(1000, 2);
        send_position(PW'(4000105));
        send_position(PW'(4001101));
        send_position(PW'(4001104));
    endtask

    // Positions going backward: the pop stops at the first entry in window.
    task automatic test_decreasing;
        drain();
        set_config(100, 4);
        send_position(PW'(50000));
        send_position(PW'(40000));
    endtask

    // WINDOW_MAX window and the largest limit: push the queue to 255 entries, then
    // jump far ahead so that one request pops every entry.
    task automatic test_queue_fill;
        longint unsigned cur;
        drain();
        set_config(WINDOW_MAX, 255);
        cur = $urandom_range(1, 1000);
        for (int i = 0; i < 270; i++)
        begin
            cur += $urandom_range(1, 3);
            send_position(PW'(cur));
        end
        cur += WINDOW_MAX + $urandom_range(0, 50);
        send_position(PW'(cur));
        send_position(PW'(cur + 1));
    endtask

    // Random streams in chunks, each under its own register setting.
    // Most steps stay inside the window, some jump far ahead, a few go back.
    task automatic test_random_stream(input int chunks, input int per_chunk);
        longint unsigned cur;
        int unsigned wl;
        int unsigned mu;
        int unsigned span;
        int unsigned d;
        int r;
        cur = 1;
        for (int c = 0; c < chunks; c++)
        begin
            // rotate the idle pattern: sender light, then receiver light, then none
            case (c * 3 / chunks)
                0: begin send_idle_pct = 24; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            drain();
            r = $urandom_range(0, 9);
            if (r == 0)
                wl = 0;
            else if (r == 1)
                wl = WINDOW_MAX;
            else if (r <= 3)
                wl = $urandom_range(1, 2000);
            else
                wl = $urandom_range(1, 64);
            r = $urandom_range(0, 9);
            if (r == 0)
                mu = 0;
            else if (r == 1)
                mu = 255;
            else
                mu = $urandom_range(1, 12);
            set_config(wl, mu);
            span = (wl < 4) ? 4 : wl;
            // now and then start high so the top position bits toggle
            if ($urandom_range(0, 3) == 0)
                cur = $urandom_range(32'h4000_0000, 32'h7FF0_0000);
            for (int i = 0; i < per_chunk; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    d = $urandom_range(0, span);
                    cur = (cur > d) ? cur - d : 1;
                end
                else if (r < 14)
                    cur += $urandom_range(1, 1 << 22);
                else
                    cur += $urandom_range(1, span);
                if (cur > POS_MAX)
                    cur = $urandom_range(1, 1000);
                send_position(PW'(cur));
                // let the block empty out once in the middle of each chunk
                if (i == per_chunk / 2)
                    drain();
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 82;
        test_reset_defaults();
        test_window_extremes();
        test_limit_zero();
        test_limit_lowered();
        test_decreasing();

        send_idle_pct = 82;
        recv_idle_pct = 24;
        test_queue_fill();

        test_random_stream(9, 40);

        // wait for the last decisions, then a short tail for stray results
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_decisions.size() == 0)
            $display("** sliding_window_density_selector_core: PASSED **");
        else
            $display("** sliding_window_density_selector_core: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("** sliding_window_density_selector_core: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/swds_pkg.sv
rtl/swds_ram.sv
rtl/sliding_window_density_selector_core.sv
tb/tb_top.sv
